@@ src/hfp_pkg.sv @@
// Shared types, codes and character helpers for the hex frame parser.
// No dependencies; used by every module of the block.
package hfp_pkg;

   localparam int unsigned CharWidth        = 8;
   localparam int unsigned NibWidth         = 4;
   localparam int unsigned CsrDataWidth     = 32;
   localparam int unsigned CsrAddrWidth     = 3;
   localparam int unsigned QueueDepthDefault = 2;

   localparam logic [CharWidth-1:0] StarChar      = 8'h2A;
   localparam logic [CharWidth-1:0] StartCharReset = 8'h4C;   // 'L'

   // register word index within the csr space
   localparam logic RegStartChar = 1'b0;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_BEGIN  = 2'd1,
      EV_DATA   = 2'd2,
      EV_COMMIT = 2'd3
   } ev_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_DATA  = 3'b010,
      PH_CHECK = 3'b100
   } phase_type;

   // classified character, as it travels from front to back
   typedef struct packed {
      logic [CharWidth-1:0] code;
      logic [NibWidth-1:0]  nib;
      logic                 is_hex;
      logic                 is_star;
      logic                 is_start;
   } cls_type;

   // upper case hex only; lower case letters are not digits
   function automatic logic is_hex_char(input logic [CharWidth-1:0] c);
      is_hex_char = ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h46));
   endfunction

   function automatic logic [NibWidth-1:0] hex_nib(input logic [CharWidth-1:0] c);
      logic [CharWidth-1:0] v;
      if (c <= 8'h39) begin
         v = c - 8'h30;
      end else begin
         v = c - 8'h37;
      end
      hex_nib = v[NibWidth-1:0];
   endfunction

endpackage

@@ src/hfp_front.sv @@
// Front stage: takes characters and classifies them into one registered beat.
// Depends on hfp_pkg.
module hfp_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [hfp_pkg::CharWidth-1:0] req_rx_char,
   input  logic [hfp_pkg::CharWidth-1:0] start_char,
   output logic                       dn_valid,
   input  logic                       dn_stall,
   output hfp_pkg::cls_type           dn_beat
);
   import hfp_pkg::*;

   logic    valid_ff, valid_in;
   cls_type beat_ff, beat_in;
   logic    take;

   assign req_stall = valid_ff && dn_stall;
   assign take      = req_valid && !req_stall;

   always_comb begin
      beat_in.code     = req_rx_char;
      beat_in.nib      = hex_nib(req_rx_char);
      beat_in.is_hex   = is_hex_char(req_rx_char);
      beat_in.is_star  = (req_rx_char == StarChar);
      // the user must change start_char only while idle; not enforced here
      beat_in.is_start = (req_rx_char == start_char);
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (!dn_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         beat_ff <= beat_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_beat  = beat_ff;

endmodule

@@ src/hfp_queue.sv @@
// Short FIFO of classified beats between front and back.
// Depends on hfp_pkg.
module hfp_queue #(
   parameter int unsigned DEPTH = hfp_pkg::QueueDepthDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_stall,
   input  hfp_pkg::cls_type in_beat,
   output logic             out_valid,
   input  logic             out_stall,
   output hfp_pkg::cls_type out_beat
);
   import hfp_pkg::*;

   localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
   localparam logic [CntWidth-1:0] FullCnt = CntWidth'(DEPTH);

   cls_type             slot_ff [DEPTH];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic                push, pop;

   assign in_stall  = (count_ff == FullCnt);
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;
   assign out_beat  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_beat;
      end
   end

endmodule

@@ src/hfp_back.sv @@
// Back stage: frame state machine, checksum and the registered result beat.
// Depends on hfp_pkg.
module hfp_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   output logic                          q_stall,
   input  hfp_pkg::cls_type              q_beat,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_event_res,
   output logic [hfp_pkg::CharWidth-1:0] rsp_data_byte
);
   import hfp_pkg::*;

   phase_type            phase_ff, phase_in;
   logic [NibWidth-1:0]  high_ff, high_in;
   logic                 have_high_ff, have_high_in;
   logic [CharWidth-1:0] sum_ff, sum_in;
   logic                 out_valid_ff, out_valid_in;
   ev_type               ev_ff, ev_in;
   logic [CharWidth-1:0] byte_ff, byte_in;
   logic                 fire;
   logic [CharWidth-1:0] pair;

   // output register frees up as soon as its beat is taken
   assign q_stall = out_valid_ff && rsp_stall;
   assign fire    = q_valid && !q_stall;
   assign pair    = {high_ff, q_beat.nib};

   always_comb begin
      phase_in     = phase_ff;
      high_in      = high_ff;
      have_high_in = have_high_ff;
      sum_in       = sum_ff;
      ev_in        = EV_NONE;
      byte_in      = '0;
      out_valid_in = out_valid_ff && rsp_stall;
      if (fire) begin
         out_valid_in = 1'b1;
         unique case (phase_ff)
            PH_DATA: begin
               if (q_beat.is_star) begin
                  have_high_in = 1'b0;
                  phase_in     = PH_CHECK;
               end else if (!q_beat.is_hex) begin
                  phase_in = PH_IDLE;
               end else begin
                  if (have_high_ff) begin
                     byte_in      = pair;
                     ev_in        = EV_DATA;
                     have_high_in = 1'b0;
                  end else begin
                     high_in      = q_beat.nib;
                     have_high_in = 1'b1;
                  end
                  sum_in = sum_ff + q_beat.code;
               end
            end
            PH_CHECK: begin
               if (!q_beat.is_hex) begin
                  phase_in = PH_IDLE;
               end else if (!have_high_ff) begin
                  high_in      = q_beat.nib;
                  have_high_in = 1'b1;
               end else begin
                  have_high_in = 1'b0;
                  if (pair == sum_ff) begin
                     ev_in = EV_COMMIT;
                  end
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               phase_in = PH_IDLE;
               if (q_beat.is_start) begin
                  have_high_in = 1'b0;
                  high_in      = '0;
                  sum_in       = '0;
                  phase_in     = PH_DATA;
                  ev_in        = EV_BEGIN;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         high_ff      <= '0;
         have_high_ff <= 1'b0;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         high_ff      <= high_in;
         have_high_ff <= have_high_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         ev_ff   <= ev_in;
         byte_ff <= byte_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_event_res = ev_ff;
   assign rsp_data_byte = byte_ff;

endmodule

@@ src/hex_frame_parser_with_checksum.sv @@
// Top level of the ASCII hex frame parser: csr register, front, queue, back.
// Depends on hfp_pkg, hfp_front, hfp_queue and hfp_back.

// One character per beat in, exactly one result beat out per character
// (event none, begin, data byte or checksum commit). Characters can be
// accepted every clock while nothing stalls; a character's result is
// registered in turn in the front register, a queue slot and the output
// register before it shows on the result port.
// The queue of QUEUE_DEPTH beats lets the input keep flowing for a while when
// the result side stalls. start_char sits at csr byte address 0 and resets
// to 'L'; write it only while the parser holds no beats in flight.
module hex_frame_parser_with_checksum #(
   parameter int unsigned QUEUE_DEPTH = hfp_pkg::QueueDepthDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [hfp_pkg::CharWidth-1:0]    req_rx_char,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_event_res,
   output logic [hfp_pkg::CharWidth-1:0]    rsp_data_byte,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [hfp_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [hfp_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic [hfp_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic                             csr_pready
);
   import hfp_pkg::*;

   logic [CharWidth-1:0] start_char_ff, start_char_in;
   logic                 csr_wr;
   logic                 f_valid, f_stall;
   cls_type              f_beat;
   logic                 q_valid, q_stall;
   cls_type              q_beat;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      start_char_in = start_char_ff;
      if (csr_wr && (csr_paddr[2] == RegStartChar)) begin
         start_char_in = csr_pwdata[CharWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_char_ff <= StartCharReset;
      end else begin
         start_char_ff <= start_char_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == RegStartChar)
                     ? {{(CsrDataWidth-CharWidth){1'b0}}, start_char_ff}
                     : '0;

   hfp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_char (req_rx_char),
      .start_char  (start_char_ff),
      .dn_valid    (f_valid),
      .dn_stall    (f_stall),
      .dn_beat     (f_beat)
   );

   hfp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_stall  (f_stall),
      .in_beat   (f_beat),
      .out_valid (q_valid),
      .out_stall (q_stall),
      .out_beat  (q_beat)
   );

   hfp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_stall       (q_stall),
      .q_beat        (q_beat),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_event_res (rsp_event_res),
      .rsp_data_byte (rsp_data_byte)
   );

endmodule

@@ src/hfp_checker.sv @@
// Port-level checks for the hex frame parser, bound onto the top level.
// Depends on hfp_pkg and hex_frame_parser_with_checksum.
module hfp_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic [hfp_pkg::CharWidth-1:0]    req_rx_char,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [1:0]                       rsp_event_res,
   input logic [hfp_pkg::CharWidth-1:0]    rsp_data_byte,
   input logic                             csr_psel,
   input logic                             csr_penable,
   input logic                             csr_pwrite,
   input logic [hfp_pkg::CsrAddrWidth-1:0] csr_paddr,
   input logic [hfp_pkg::CsrDataWidth-1:0] csr_pwdata,
   input logic [hfp_pkg::CsrDataWidth-1:0] csr_prdata,
   input logic                             csr_pready
);
   import hfp_pkg::*;

   // a result beat under stall stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_res)
                                  && $stable(rsp_data_byte))
      else $error("result beat changed while stalled");

   // an input beat under stall is held by the sender
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_rx_char))
      else $error("input beat changed while stalled");

   assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res != EV_DATA) |-> (rsp_data_byte == '0))
      else $error("data byte nonzero on a non-data event");

   // written start character reads back on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_pready
      && (csr_paddr[2] == RegStartChar)
      |=> (csr_paddr[2] != RegStartChar)
          || (csr_psel && csr_penable && csr_pwrite)
          || (csr_prdata[CharWidth-1:0] == $past(csr_pwdata[CharWidth-1:0])))
      else $error("start character readback mismatch");

endmodule

bind hex_frame_parser_with_checksum hfp_checker u_hfp_checker (.*);
